@@ design/spi_eeprom_device_model_top_macros.svh @@
// Assertion macros used by the checker file of the SPI EEPROM device model.
`ifndef SPI_EEPROM_DEVICE_MODEL_TOP_MACROS_SVH
`define SPI_EEPROM_DEVICE_MODEL_TOP_MACROS_SVH

// Checked at every clock edge, reset included.
`define SEDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define SEDM_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ design/sedm_pkg.sv @@
// Package with the types, constants and helper functions of the SPI EEPROM device model.
package sedm_pkg;

  // Storage geometry.
  localparam int MEM_DEPTH = 512;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int HOLD_W    = 9;
  localparam int BYTE_W    = 8;
  localparam int OP_W      = 2;
  localparam int TICK_W    = 16;

  // Reset value of the programming time in ticks.
  localparam logic [TICK_W-1:0] WRITE_TIME_RESET = 16'd5000;

  // Command bytes and masks.
  localparam logic [BYTE_W-1:0] OPC_READ   = 8'h03;
  localparam logic [BYTE_W-1:0] OPC_WRITE  = 8'h02;
  localparam logic [BYTE_W-1:0] OPC_WREN   = 8'h06;
  localparam logic [BYTE_W-1:0] OPC_RDSR   = 8'h05;
  localparam logic [BYTE_W-1:0] CMD_A8MASK = 8'hF7;
  localparam logic [BYTE_W-1:0] ERASED     = 8'hFF;

  // Kind of input beat.
  typedef enum logic [OP_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_DESEL = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // Decoded command of the current frame.
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_READ  = 3'd1,
    KIND_WRITE = 3'd2,
    KIND_WREN  = 3'd3,
    KIND_RDSR  = 3'd4
  } kind_t;

  typedef logic [ADDR_W-1:0] cell_addr_t;

  // Request from the frame controller to the cell store.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    cell_addr_t        addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

  // While busy only a status read is recognized.
  function automatic kind_t decode_cmd(input logic [BYTE_W-1:0] b, input logic busy);
    kind_t k;
    k = KIND_NONE;
    if (busy) begin
      if (b == OPC_RDSR) k = KIND_RDSR;
    end else if ((b & CMD_A8MASK) == OPC_READ) begin
      k = KIND_READ;
    end else if ((b & CMD_A8MASK) == OPC_WRITE) begin
      k = KIND_WRITE;
    end else if (b == OPC_WREN) begin
      k = KIND_WREN;
    end else if (b == OPC_RDSR) begin
      k = KIND_RDSR;
    end
    return k;
  endfunction

  // Address wraps modulo the depth; the held address stays below twice the depth.
  function automatic cell_addr_t cell_index(input logic [HOLD_W-1:0] a);
    logic [HOLD_W:0] w;
    w = {1'b0, a};
    if (w >= (HOLD_W+1)'(MEM_DEPTH)) w = w - (HOLD_W+1)'(MEM_DEPTH);
    return w[ADDR_W-1:0];
  endfunction

endpackage

@@ design/sedm_ifs.sv @@
// Valid/ready channel interfaces of the SPI EEPROM device model.
interface sedm_in_if;
  logic                         valid;
  logic                         ready;
  logic [sedm_pkg::OP_W-1:0]    op;
  logic [sedm_pkg::BYTE_W-1:0]  mosi_byte;
  modport source (output valid, output op, output mosi_byte, input ready);
  modport sink   (input valid, input op, input mosi_byte, output ready);
endinterface

interface sedm_out_if;
  logic                         valid;
  logic                         ready;
  logic [sedm_pkg::BYTE_W-1:0]  miso_byte;
  modport source (output valid, output miso_byte, input ready);
  modport sink   (input valid, input miso_byte, output ready);
endinterface

interface sedm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sedm_pkg::TICK_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/sedm_cell_store.sv @@
// Byte array of the EEPROM with registered read and the erase sweep after reset.
module sedm_cell_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sedm_pkg::mem_req_t          req_i,
  output logic [sedm_pkg::BYTE_W-1:0] rd_data_o,
  output logic                        ready_o
);

  logic [sedm_pkg::BYTE_W-1:0] mem [sedm_pkg::MEM_DEPTH];

  sedm_pkg::cell_addr_t        clr_addr_r, clr_addr_nxt;
  logic                        clr_done_r, clr_done_nxt;
  logic [sedm_pkg::BYTE_W-1:0] rd_data_r;

  logic                        we;
  sedm_pkg::cell_addr_t        wa;
  logic [sedm_pkg::BYTE_W-1:0] wd;

  // Erase sweep: one entry per cycle until the last address is written.
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clr_done_nxt = clr_done_r;
    if (!clr_done_r) begin
      if (clr_addr_r == sedm_pkg::cell_addr_t'(sedm_pkg::MEM_DEPTH - 1)) begin
        clr_done_nxt = 1'b1;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_done_r <= 1'b0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clr_done_r <= clr_done_nxt;
    end
  end

  // The sweep owns the write port until it is done.
  always_comb begin
    if (!clr_done_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = sedm_pkg::ERASED;
    end else begin
      we = req_i.wr_en;
      wa = req_i.addr;
      wd = req_i.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Read data is held until the next read.
  always_ff @(posedge clk) begin
    if (req_i.rd_en) begin
      rd_data_r <= mem[req_i.addr];
    end
  end

  assign rd_data_o = rd_data_r;
  assign ready_o   = clr_done_r;

endmodule

@@ design/sedm_frame_ctrl.sv @@
// Frame decoder, status registers, busy timer and output register of the EEPROM model.
module sedm_frame_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  sedm_in_if.sink                     in_if,
  sedm_out_if.source                  out_if,
  sedm_cfg_if.sink                    cfg_if,
  input  logic [sedm_pkg::BYTE_W-1:0] rd_data_i,
  input  logic                        store_ready_i,
  output sedm_pkg::mem_req_t          req_o
);

  logic [1:0]                    frame_pos_r, frame_pos_nxt;
  sedm_pkg::kind_t               kind_r, kind_nxt;
  logic [sedm_pkg::HOLD_W-1:0]   addr_r, addr_nxt;
  logic [sedm_pkg::BYTE_W-1:0]   data_r, data_nxt;
  logic                          held_r, held_nxt;
  logic                          wel_r, wel_nxt;
  logic                          busy_r, busy_nxt;
  logic [sedm_pkg::TICK_W-1:0]   cnt_r, cnt_nxt;
  logic [sedm_pkg::TICK_W-1:0]   wtime_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [sedm_pkg::BYTE_W-1:0]   out_data_r, out_data_nxt;

  logic                          in_acc;
  logic [sedm_pkg::BYTE_W-1:0]   reply;
  logic [sedm_pkg::TICK_W-1:0]   cnt_dec;
  logic [sedm_pkg::HOLD_W-1:0]   addr_full;

  // A new beat is taken once the sweep is done, while the output slot is empty or being drained.
  assign in_if.ready = store_ready_i && (!out_valid_r || out_if.ready);
  assign in_acc      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign addr_full   = {addr_r[sedm_pkg::HOLD_W-1], in_if.mosi_byte};

  // Next state of the frame and the status registers.
  always_comb begin
    frame_pos_nxt = frame_pos_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    held_nxt      = held_r;
    wel_nxt       = wel_r;
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    reply         = '0;
    cnt_dec       = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
    req_o         = '{wr_en: 1'b0, rd_en: 1'b0, addr: '0, wdata: '0};
    if (in_acc) begin
      case (sedm_pkg::op_t'(in_if.op))
        sedm_pkg::OP_BYTE: begin
          case (frame_pos_r)
            2'd0: begin
              kind_nxt = sedm_pkg::decode_cmd(in_if.mosi_byte, busy_r);
              addr_nxt = {in_if.mosi_byte[3], 8'h00};
            end
            2'd1: begin
              if (kind_r == sedm_pkg::KIND_READ || kind_r == sedm_pkg::KIND_WRITE) begin
                addr_nxt    = addr_full;
                req_o.rd_en = 1'b1;
                req_o.addr  = sedm_pkg::cell_index(addr_full);
              end else if (kind_r == sedm_pkg::KIND_RDSR) begin
                reply = {6'b0, wel_r, busy_r};
              end
            end
            2'd2: begin
              if (kind_r == sedm_pkg::KIND_READ) begin
                reply = rd_data_i;
              end else if (kind_r == sedm_pkg::KIND_WRITE) begin
                data_nxt = in_if.mosi_byte;
                held_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (frame_pos_r != 2'd3) frame_pos_nxt = frame_pos_r + 1'b1;
        end
        sedm_pkg::OP_DESEL: begin
          // Program the held byte, or set the latch after WREN.
          if (kind_r == sedm_pkg::KIND_WRITE && held_r && wel_r) begin
            req_o.wr_en = 1'b1;
            req_o.addr  = sedm_pkg::cell_index(addr_r);
            req_o.wdata = data_r;
            wel_nxt     = 1'b0;
            busy_nxt    = 1'b1;
            cnt_nxt     = (wtime_r == '0) ? sedm_pkg::TICK_W'(1) : wtime_r;
          end else if (kind_r == sedm_pkg::KIND_WREN) begin
            wel_nxt = 1'b1;
          end
          frame_pos_nxt = 2'd0;
          kind_nxt      = sedm_pkg::KIND_NONE;
          held_nxt      = 1'b0;
        end
        sedm_pkg::OP_TICK: begin
          if (busy_r) begin
            cnt_nxt  = cnt_dec;
            busy_nxt = (cnt_dec != '0);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: loaded by every byte beat, emptied when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_acc && in_if.op == sedm_pkg::OP_BYTE) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = reply;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pos_r <= 2'd0;
      kind_r      <= sedm_pkg::KIND_NONE;
      addr_r      <= '0;
      data_r      <= '0;
      held_r      <= 1'b0;
      wel_r       <= 1'b0;
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      wtime_r     <= sedm_pkg::WRITE_TIME_RESET;
      out_valid_r <= 1'b0;
    end else begin
      frame_pos_r <= frame_pos_nxt;
      kind_r      <= kind_nxt;
      addr_r      <= addr_nxt;
      data_r      <= data_nxt;
      held_r      <= held_nxt;
      wel_r       <= wel_nxt;
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) wtime_r <= cfg_if.data;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.miso_byte = out_data_r;

endmodule

@@ design/spi_eeprom_device_model_top.sv @@
// Top level of the byte-level SPI EEPROM device model.
//
// The in_if channel carries one beat per item: op 0 is a MOSI byte while the
// chip is selected, op 1 a deselect and op 2 a time tick. Every byte beat gives
// exactly one out_if beat with the MISO byte; deselects and ticks give none.
// cfg_if writes the programming time in ticks and is always ready.
// Throughput is one item per cycle while in_if.ready is high. A result is
// registered in the cycle after its byte is accepted; the READ data byte
// comes from the cell array, which is read when the address byte is taken,
// so the single registered read port never sits on the reply path. Writes
// are programmed into the array on deselect. After reset the array is swept
// to 0xFF, one entry per cycle, and in_if.ready stays low until the sweep is
// done; configuration writes are taken during the sweep. The output register
// lets a new beat enter while a result is being taken; when the receiver holds
// out_if.ready low with a result waiting, in_if.ready drops until it leaves.
module spi_eeprom_device_model_top (
  input  logic       clk,
  input  logic       rst_n,
  sedm_in_if.sink    in_if,
  sedm_out_if.source out_if,
  sedm_cfg_if.sink   cfg_if
);

  sedm_pkg::mem_req_t          mem_req;
  logic [sedm_pkg::BYTE_W-1:0] rd_data;
  logic                        store_ready;

  sedm_cell_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (mem_req),
    .rd_data_o (rd_data),
    .ready_o   (store_ready)
  );

  sedm_frame_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_if         (in_if),
    .out_if        (out_if),
    .cfg_if        (cfg_if),
    .rd_data_i     (rd_data),
    .store_ready_i (store_ready),
    .req_o         (mem_req)
  );

endmodule

@@ design/sedm_checker.sv @@
// Port-level checker of the SPI EEPROM device model and its bind to the top level.
`include "spi_eeprom_device_model_top_macros.svh"

module sedm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [sedm_pkg::OP_W-1:0]   in_op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sedm_pkg::BYTE_W-1:0] out_miso
);

  logic in_acc;
  logic in_byte;
  logic out_stall;

  // Handshake terms used by the checks below.
  assign in_acc    = in_valid && in_ready;
  assign in_byte   = (in_op == sedm_pkg::OP_BYTE);
  assign out_stall = out_valid && !out_ready;

  // Reset empties the output slot and starts the erase sweep.
  `SEDM_ASSERT_ALWAYS(a_rst_out_empty, !rst_n |=> !out_valid, "output valid after reset")
  `SEDM_ASSERT_ALWAYS(a_rst_sweep, !rst_n |=> !in_ready, "input ready during erase sweep")

  // Each byte beat gives one result; other beats give none.
  `SEDM_ASSERT_RUN(a_byte_result, in_acc && in_byte |=> out_valid, "byte beat without result")
  `SEDM_ASSERT_RUN(a_no_result, in_acc && !in_byte |=> !out_valid, "result from non-byte beat")

  // A stalled result holds.
  `SEDM_ASSERT_RUN(a_out_hold, out_stall |=> out_valid && $stable(out_miso), "stalled result changed")

endmodule

bind spi_eeprom_device_model_top sedm_checker u_sedm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_op     (in_if.op),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_miso  (out_if.miso_byte)
);
